FILE: rtl/dbpp_pkg.sv
package dbpp_pkg;

    // store geometry
    localparam int STORE_BYTES_DEF = 1024;
    localparam int LOAD_ADDR_W     = 10;

    // field widths
    localparam int SAMPLE_W  = 8;
    localparam int SPS_W     = 16;
    localparam int BCD_W     = 8;
    localparam int SECONDS_W = 7;

    // samples per second after reset
    localparam logic [SPS_W-1:0] SPS_RESET = 16'd44100;

    // bcd arithmetic
    localparam logic [BCD_W-1:0] BCD_HI_MASK   = 8'b11110000;
    localparam logic [BCD_W-1:0] BCD_ADJUST    = 8'b00000110;
    localparam logic [BCD_W-1:0] BCD_DIGIT_MAX = 8'd9;
    localparam logic [BCD_W-1:0] SECONDS_WRAP  = 8'h60;
    localparam logic [BCD_W-1:0] MINUTES_WRAP  = 8'hA0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_STOP = 2'd2,
        OP_PLAY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic [SAMPLE_W-1:0]    load_data;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  left_sample;
        logic [SAMPLE_W-1:0]  right_sample;
        logic [SECONDS_W-1:0] seconds_bcd;
        logic [BCD_W-1:0]     minutes_bcd;
        logic                 refill_request;
        logic                 refill_half;
        logic                 is_playing;
    } t_out_item;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_timer_ctl;

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] s;
        s = v + 8'd1;
        if ((s & ~BCD_HI_MASK) > BCD_DIGIT_MAX) begin
            s = s + BCD_ADJUST;
        end
        return s;
    endfunction

endpackage

FILE: rtl/double_buffered_pcm_player.sv
// stereo pcm player over a byte store split into a lower and an upper half
// input channel (i_in_valid / o_in_stall) carries one of four transactions:
//   sample tick, load one byte into the store, stop and clear, play
// output channel (o_out_valid / i_out_stall) returns exactly one result per
// input transaction: current left/right levels, elapsed time in bcd, a
// one-shot refill request naming the half just vacated, and the play flag
// pipeline: two register stages (state update, then registered store read into
// the output register); each accepted transaction passes through the middle
// stage and then the output register before its result is valid
// throughput: one transaction per cycle unless stalled; the store has one write
// port and two registered read ports, so both bytes of a tick are fetched together
// a stall on the output holds the output register, then the middle stage,
// and only then is o_in_stall raised; nothing is dropped or duplicated
// i_cfg_we writes samples_per_second; it is used at the next countdown
// reload or stop, and should only be written while the block is idle
// reset (synchronous, active low) stops playback and clears positions,
// counters and levels; the store itself is not cleared and must be loaded
module double_buffered_pcm_player #(
    parameter int STORE_BYTES = dbpp_pkg::STORE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dbpp_pkg::t_in_item             i_in_item,
    // result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dbpp_pkg::t_out_item            o_out_item,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [dbpp_pkg::SPS_W-1:0]     i_cfg_wdata
);
    import dbpp_pkg::*;

    localparam int AW   = $clog2(STORE_BYTES);
    localparam int PW   = AW + 1;
    localparam int HALF = STORE_BYTES / 2;
    // wide enough for both the load address and the store size
    localparam int XW   = ((AW > LOAD_ADDR_W) ? AW : LOAD_ADDR_W) + 1;

    // sample store, contents undefined until loaded
    logic [SAMPLE_W-1:0] r_store [STORE_BYTES];

    logic [SPS_W-1:0]    r_sps;
    logic [AW-1:0]       r_pos, n_pos;
    logic                r_playing, n_playing;
    logic                r_next_half, n_next_half;

    // middle stage
    logic                r_s1_valid;
    logic                r_s1_tick;
    logic                r_s1_req;
    logic                r_s1_half;
    logic [SAMPLE_W-1:0] r_rd_left;
    logic [SAMPLE_W-1:0] r_rd_right;

    // output stage
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic [SAMPLE_W-1:0] r_left_level, n_left_level;
    logic [SAMPLE_W-1:0] r_right_level, n_right_level;

    logic                en1, en2, accept;
    logic                tick, clear, store_we, req, half;
    logic [PW-1:0]       pos_p1_w, pos_p2_w;
    logic [AW-1:0]       pos_p1, pos_p2;
    logic [XW-1:0]       load_addr_x;
    logic                load_in_range;
    t_timer_ctl          timer_ctl;
    logic [BCD_W-1:0]    seconds_bcd, minutes_bcd;

    // handshake: the middle stage moves when the output register can take it
    assign en2        = !r_out_valid || !i_out_stall;
    assign en1        = !r_s1_valid || en2;
    assign o_in_stall = !en1;
    assign accept     = i_in_valid && en1;

    // next two byte positions, each wrapping at the end of the store
    assign pos_p1_w = {1'b0, r_pos} + PW'(1);
    assign pos_p1   = (pos_p1_w >= PW'(STORE_BYTES)) ? '0 : pos_p1_w[AW-1:0];
    assign pos_p2_w = {1'b0, pos_p1} + PW'(1);
    assign pos_p2   = (pos_p2_w >= PW'(STORE_BYTES)) ? '0 : pos_p2_w[AW-1:0];

    // loads outside the store are dropped
    assign load_addr_x   = XW'(i_in_item.load_addr);
    assign load_in_range = load_addr_x < XW'(STORE_BYTES);

    always_comb begin
        n_pos       = r_pos;
        n_playing   = r_playing;
        n_next_half = r_next_half;
        tick        = 1'b0;
        clear       = 1'b0;
        store_we    = 1'b0;
        req         = 1'b0;
        half        = 1'b0;
        if (accept) begin
            unique case (i_in_item.op)
                OP_TICK: begin
                    // ticks are ignored while stopped
                    if (r_playing) begin
                        tick  = 1'b1;
                        n_pos = pos_p2;
                    end
                end
                OP_LOAD: begin
                    store_we = load_in_range;
                end
                OP_STOP: begin
                    n_playing   = 1'b0;
                    n_pos       = '0;
                    n_next_half = 1'b0;
                    clear       = 1'b1;
                end
                OP_PLAY: begin
                    n_playing = 1'b1;
                end
                default: begin
                    n_playing = r_playing;
                end
            endcase
            // refill check after every transaction while playing:
            // once the read position has crossed into the other half,
            // the half it left may be refilled
            if (n_playing) begin
                if (!r_next_half) begin
                    if ({1'b0, n_pos} >= PW'(HALF)) begin
                        req         = 1'b1;
                        half        = 1'b0;
                        n_next_half = 1'b1;
                    end
                end else begin
                    if ({1'b0, n_pos} < PW'(HALF)) begin
                        req         = 1'b1;
                        half        = 1'b1;
                        n_next_half = 1'b0;
                    end
                end
            end
        end
    end

    assign timer_ctl.tick  = tick;
    assign timer_ctl.clear = clear;

    dbpp_timer u_timer (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (timer_ctl),
        .i_samples_per_second (r_sps),
        .o_seconds_bcd        (seconds_bcd),
        .o_minutes_bcd        (minutes_bcd)
    );

    // store write port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[load_addr_x[AW-1:0]] <= i_in_item.load_data;
        end
    end

    // two registered read ports, left and right byte of the current frame
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_rd_left  <= r_store[r_pos];
            r_rd_right <= r_store[pos_p1];
        end
    end

    // middle stage payload; the timer and play flag registers change only
    // on accept, so they stay aligned with this stage
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_tick <= tick;
            r_s1_req  <= req;
            r_s1_half <= half;
        end
    end

    // levels are only replaced by a tick that played
    assign n_left_level  = r_s1_tick ? r_rd_left  : r_left_level;
    assign n_right_level = r_s1_tick ? r_rd_right : r_right_level;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps         <= SPS_RESET;
            r_pos         <= '0;
            r_playing     <= 1'b0;
            r_next_half   <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_left_level  <= '0;
            r_right_level <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sps <= i_cfg_wdata;
            end
            r_pos       <= n_pos;
            r_playing   <= n_playing;
            r_next_half <= n_next_half;
            if (en1) begin
                r_s1_valid <= accept;
            end
            if (en2) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_left_level  <= n_left_level;
                    r_right_level <= n_right_level;
                end
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_valid) begin
            r_out_item.left_sample    <= n_left_level;
            r_out_item.right_sample   <= n_right_level;
            r_out_item.seconds_bcd    <= seconds_bcd[SECONDS_W-1:0];
            r_out_item.minutes_bcd    <= minutes_bcd;
            r_out_item.refill_request <= r_s1_req;
            r_out_item.refill_half    <= r_s1_half;
            r_out_item.is_playing     <= r_playing;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/dbpp_timer.sv
module dbpp_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dbpp_pkg::t_timer_ctl           i_ctl,
    input  logic [dbpp_pkg::SPS_W-1:0]     i_samples_per_second,
    output logic [dbpp_pkg::BCD_W-1:0]     o_seconds_bcd,
    output logic [dbpp_pkg::BCD_W-1:0]     o_minutes_bcd
);
    import dbpp_pkg::*;

    logic [SPS_W-1:0] r_countdown, n_countdown;
    logic [BCD_W-1:0] r_seconds, n_seconds;
    logic [BCD_W-1:0] r_minutes, n_minutes;

    always_comb begin
        n_countdown = r_countdown;
        n_seconds   = r_seconds;
        n_minutes   = r_minutes;
        if (i_ctl.clear) begin
            n_countdown = i_samples_per_second;
            n_seconds   = '0;
            n_minutes   = '0;
        end else if (i_ctl.tick) begin
            n_countdown = r_countdown - 16'd1;
            if (n_countdown == '0) begin
                n_countdown = i_samples_per_second;
                n_seconds   = bcd_inc(r_seconds);
            end
            // minute rollover, 99:59 goes back to 00:00
            if (n_seconds == SECONDS_WRAP) begin
                n_seconds = '0;
                n_minutes = bcd_inc(r_minutes);
                if (n_minutes == MINUTES_WRAP) begin
                    n_minutes = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= SPS_RESET;
            r_seconds   <= '0;
            r_minutes   <= '0;
        end else begin
            r_countdown <= n_countdown;
            r_seconds   <= n_seconds;
            r_minutes   <= n_minutes;
        end
    end

    assign o_seconds_bcd = r_seconds;
    assign o_minutes_bcd = r_minutes;

endmodule
